@@ rtl/xs_pkg.sv @@
// Shared types and the data-width constant for the exchange sorter.
package xs_pkg;

  localparam int unsigned DATA_W = 32;

  // One slot of the cell chain: a held value or a value in flight.
  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] data;
  } slot_t;

  // Top-level sequencer phases.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/xs_cell.sv @@
// Insertion chain cell: keeps the smaller value, passes larger on, or shifts left.
module xs_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  input  xs_pkg::slot_t carry_in,
  input  xs_pkg::slot_t right_held,
  output xs_pkg::slot_t carry_out,
  output xs_pkg::slot_t held
);

  logic                             held_vld_r, held_vld_nxt;
  logic signed [xs_pkg::DATA_W-1:0] held_data_r, held_data_nxt;
  logic                             carry_vld_r, carry_vld_nxt;
  logic signed [xs_pkg::DATA_W-1:0] carry_data_r, carry_data_nxt;

  // Insert or shift decision
  always_comb begin
    held_vld_nxt   = held_vld_r;
    held_data_nxt  = held_data_r;
    carry_vld_nxt  = 1'b0;
    carry_data_nxt = carry_data_r;
    if (shift) begin
      // emit phase: take the right neighbour's value
      held_vld_nxt  = right_held.vld;
      held_data_nxt = right_held.data;
    end else if (carry_in.vld) begin
      if (!held_vld_r) begin
        held_vld_nxt  = 1'b1;
        held_data_nxt = carry_in.data;
      end else if (carry_in.data < held_data_r) begin
        held_data_nxt  = carry_in.data;
        carry_vld_nxt  = 1'b1;
        carry_data_nxt = held_data_r;
      end else begin
        carry_vld_nxt  = 1'b1;
        carry_data_nxt = carry_in.data;
      end
    end
  end

  // Control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r  <= 1'b0;
      carry_vld_r <= 1'b0;
    end else begin
      held_vld_r  <= held_vld_nxt;
      carry_vld_r <= carry_vld_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    held_data_r  <= held_data_nxt;
    carry_data_r <= carry_data_nxt;
  end

  assign held.vld       = held_vld_r;
  assign held.data      = held_data_r;
  assign carry_out.vld  = carry_vld_r;
  assign carry_out.data = carry_data_r;

endmodule

@@ rtl/exchange_sorter.sv @@
// Top level of the exchange sorter: cell chain plus load, settle and emit sequencer.
//
// Use: present a value on in_value with in_last_in and raise start; the
// value is taken at a clock edge where start is high and busy is low.
// Values are loaded at one per cycle while busy is low. Up to DEPTH values
// are held; further values of the run are dropped, but an in_last_in
// transfer still closes the run.
// Each loaded value ripples through a row of DEPTH cells, one cell a
// cycle, and settles in ascending order among those already held.
// After the last transfer busy stays high while the chain settles, then
// the held values leave the chain one per cycle from the head cell: one
// result per held value on out_sorted_value, each marked by out_valid for
// one cycle, out_last_out on the final one.
// busy falls as the last result reaches the ports, so a new run may
// start while it is there. The receiver cannot stall.
// Reset (rst_n low, synchronous) empties every cell and the fill count.
module exchange_sorter #(
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [xs_pkg::DATA_W-1:0] in_value,
  input  logic                             in_last_in,
  output logic                             out_valid,
  output logic signed [xs_pkg::DATA_W-1:0] out_sorted_value,
  output logic                             out_last_out
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DRN_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
  localparam logic [DRN_W-1:0] DRAIN_LEN = DRN_W'(DEPTH - 1);

  xs_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [DRN_W-1:0] drain_r, drain_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_last_r, out_last_nxt;
  logic signed [xs_pkg::DATA_W-1:0] out_data_r;

  logic          accept;
  logic          shift;
  xs_pkg::slot_t carry [DEPTH+1];
  xs_pkg::slot_t held  [DEPTH+1];

  assign accept = start && !busy;

  // Head of the chain: an accepted value enters while there is room
  assign carry[0].vld  = accept && (count_r < FULL);
  assign carry[0].data = in_value;
  assign held[DEPTH]   = '0;

  // Row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    xs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift      (shift),
      .carry_in   (carry[g]),
      .right_held (held[g+1]),
      .carry_out  (carry[g+1]),
      .held       (held[g])
    );
  end

  // Sequencer: next state and outputs
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drain_nxt     = drain_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    shift         = 1'b0;
    busy          = 1'b1;
    case (state_r)
      xs_pkg::ST_LOAD: begin
        busy = 1'b0;
        // busy is low here, so start alone marks a transfer
        if (start) begin
          if (count_r < FULL) begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_last_in) begin
            drain_nxt = DRAIN_LEN;
            state_nxt = xs_pkg::ST_DRAIN;
          end
        end
      end
      xs_pkg::ST_DRAIN: begin
        if (drain_r == '0) begin
          state_nxt = xs_pkg::ST_EMIT;
        end else begin
          drain_nxt = drain_r - DRN_W'(1);
        end
      end
      xs_pkg::ST_EMIT: begin
        shift         = 1'b1;
        out_valid_nxt = 1'b1;
        count_nxt     = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          out_last_nxt = 1'b1;
          state_nxt    = xs_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = xs_pkg::ST_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xs_pkg::ST_LOAD;
      count_r     <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // Result data from the head cell
  always_ff @(posedge clk) begin
    if (shift) begin
      out_data_r <= held[0].data;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_data_r;
  assign out_last_out     = out_last_r;

`ifndef SYNTHESIS
  // no value may fall off the end of the chain
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !carry[DEPTH].vld)
    else $error("value carried past the last cell");

  // every emit cycle reads a held value from the head cell
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xs_pkg::ST_EMIT) |-> held[0].vld)
    else $error("emit with empty head cell");

  // results only follow an emit cycle
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == xs_pkg::ST_EMIT))
    else $error("result strobe outside emit phase");

  // a closing transfer makes the block busy
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_in) |=> busy)
    else $error("not busy after closing transfer");

  // the final mark rides on a result
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_out |-> out_valid)
    else $error("last mark without result");
`endif

endmodule
